// ===== hw/rtl/source_text_tokenizer_core_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
// STT_ASSERT checks a property on every rising clock edge outside reset.
// STT_ASSERT_NEXT checks that a condition is followed by another in the next cycle.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tokenizer assertion failed");
`define STT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define STT_ASSERT(lbl, prop)
`define STT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/stt_pkg.sv =====
package stt_pkg;

  localparam longint unsigned TEXT_BYTES_DEF = 64'd1048576;

  localparam int KEY_CHARS = 8;
  localparam int KW_COUNT  = 16;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [19:0] LEN_MAX = 20'hFFFFF;

  // Token kinds.
  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_LBRACK = 6'd4;
  localparam logic [5:0] K_RBRACK = 6'd5;
  localparam logic [5:0] K_COMMA  = 6'd6;
  localparam logic [5:0] K_NL     = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_DOT    = 6'd9;
  localparam logic [5:0] K_COLON  = 6'd10;
  localparam logic [5:0] K_PLUS   = 6'd11;
  localparam logic [5:0] K_MINUS  = 6'd12;
  localparam logic [5:0] K_STAR   = 6'd13;
  localparam logic [5:0] K_SLASH  = 6'd14;
  localparam logic [5:0] K_ASSIGN = 6'd15;
  localparam logic [5:0] K_NOT    = 6'd17;
  localparam logic [5:0] K_GT     = 6'd19;
  localparam logic [5:0] K_LT     = 6'd21;
  localparam logic [5:0] K_AND    = 6'd23;
  localparam logic [5:0] K_OR     = 6'd24;
  localparam logic [5:0] K_INT    = 6'd25;
  localparam logic [5:0] K_FLT    = 6'd26;
  localparam logic [5:0] K_DBL    = 6'd27;
  localparam logic [5:0] K_STR    = 6'd28;
  localparam logic [5:0] K_NAME   = 6'd29;
  localparam logic [5:0] K_KW0    = 6'd30;
  localparam logic [5:0] K_END    = 6'd46;

  // Name prefix: the first character sits in element 0, the most significant byte.
  typedef logic [0:KEY_CHARS-1][7:0] kw_prefix_t;

  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"bool", 32'd0}, {"break", 24'd0}, "continue", {"else", 32'd0},
    {"false", 24'd0}, {"float", 24'd0}, {"double", 16'd0}, {"fn", 48'd0},
    {"for", 40'd0}, {"if", 48'd0}, {"int", 40'd0}, {"let", 40'd0},
    {"mut", 40'd0}, {"true", 32'd0}, {"type", 32'd0}, {"use", 40'd0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd8, 4'd4, 4'd5, 4'd5, 4'd6, 4'd2,
    4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd3
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] start;
    logic [19:0] len;
    logic        err;
    logic        last;
  } tok_t;

  // Tokens produced by one accepted word.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       first;
    tok_t       second;
  } push_t;

  // Keyword lookup: parallel compare of the stored prefix against every keyword.
  function automatic logic [5:0] name_kind(kw_prefix_t pfx, logic [19:0] len);
    logic [5:0] k;
    k = K_NAME;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (len == 20'(KW_LEN[i]) && pfx == KW_TEXT[i]) begin
        k = 6'(K_KW0 + 6'(i));
      end
    end
    return k;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] op);
    logic [5:0] k;
    case (op)
      "=": begin
        k = K_ASSIGN;
      end
      "!": begin
        k = K_NOT;
      end
      ">": begin
        k = K_GT;
      end
      default: begin
        k = K_LT;
      end
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(logic [5:0] kind, logic [19:0] start, logic [19:0] len,
                                  logic err);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.err   = err;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

// ===== hw/rtl/stt_lex.sv =====
`include "source_text_tokenizer_core_assert.svh"

module stt_lex import stt_pkg::*; #(
  parameter longint unsigned TEXT_BYTES = TEXT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output push_t      push_o
);

  localparam int POS_W = $clog2(TEXT_BYTES);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_INT  = 3'd1;
  localparam logic [2:0] MODE_FRAC = 3'd2;
  localparam logic [2:0] MODE_STR  = 3'd3;
  localparam logic [2:0] MODE_NAME = 3'd4;
  localparam logic [2:0] MODE_OP   = 3'd5;

  logic [2:0]       mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] org_q, org_d;
  kw_prefix_t       pfx_q, pfx_d;
  logic [7:0]       pend_q, pend_d;
  logic [19:0]      len_q, len_d;

  logic [7:0]  b;
  logic        is_numeral, is_letter, is_ws, op_andor;
  logic [19:0] len_grow, org20, pos20;
  logic        a_emit, b_emit, again;
  tok_t        a_tok, b_tok;

  assign b          = text_byte_i;
  assign is_numeral = (b >= "0") && (b <= "9");
  assign is_letter  = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  assign is_ws      = (b == " ") || (b == 8'h09) || (b == 8'h0D);
  assign op_andor   = (pend_q == "&") || (pend_q == "|");
  assign len_grow   = (len_q == LEN_MAX) ? len_q : len_q + 20'd1;
  assign org20      = 20'(org_q);
  assign pos20      = 20'(pos_q);

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    org_d  = org_q;
    pfx_d  = pfx_q;
    pend_d = pend_q;
    len_d  = len_q;
    a_emit = 1'b0;
    a_tok  = '0;
    b_emit = 1'b0;
    b_tok  = '0;
    again  = 1'b0;

    if (end_of_text_i) begin
      // Flush whatever token is open, then the end token.
      case (mode_q)
        MODE_INT: begin
          a_emit = 1'b1;
          a_tok  = mk_tok(K_INT, org20, len_q, 1'b0);
        end
        MODE_FRAC: begin
          a_emit = 1'b1;
          a_tok  = mk_tok(K_DBL, org20, len_q, 1'b0);
        end
        MODE_STR: begin
          a_emit = 1'b1;
          a_tok  = mk_tok(K_END, org20, len_q, 1'b1);
        end
        MODE_NAME: begin
          a_emit = 1'b1;
          a_tok  = mk_tok(name_kind(pfx_q, len_q), org20, len_q, 1'b0);
        end
        MODE_OP: begin
          a_emit = 1'b1;
          if (op_andor) begin
            a_tok = mk_tok(K_END, org20, 20'd1, 1'b1);
          end else begin
            a_tok = mk_tok(single_kind(pend_q), org20, 20'd1, 1'b0);
          end
        end
        default: begin
        end
      endcase
      b_emit = 1'b1;
      b_tok  = mk_tok(K_END, pos20, 20'd0, 1'b0);
      mode_d = MODE_IDLE;
      pend_d = '0;
      len_d  = '0;
      pos_d  = '0;
    end else begin
      case (mode_q)
        MODE_INT: begin
          if (is_numeral) begin
            len_d = len_grow;
          end else if (b == ".") begin
            len_d  = len_grow;
            mode_d = MODE_FRAC;
          end else begin
            a_emit = 1'b1;
            a_tok  = mk_tok(K_INT, org20, len_q, 1'b0);
            again  = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_numeral) begin
            len_d = len_grow;
          end else if (b == ".") begin
            a_emit = 1'b1;
            a_tok  = mk_tok(K_END, org20, len_q, 1'b1);
            again  = 1'b1;
          end else if (b == "f") begin
            a_emit = 1'b1;
            a_tok  = mk_tok(K_FLT, org20, len_q, 1'b0);
            mode_d = MODE_IDLE;
          end else if (b == "d") begin
            a_emit = 1'b1;
            a_tok  = mk_tok(K_DBL, org20, len_q, 1'b0);
            mode_d = MODE_IDLE;
          end else begin
            a_emit = 1'b1;
            a_tok  = mk_tok(K_DBL, org20, len_q, 1'b0);
            again  = 1'b1;
          end
        end
        MODE_STR: begin
          len_d = len_grow;
          if (b == "\"") begin
            a_emit = 1'b1;
            a_tok  = mk_tok(K_STR, org20, len_grow, 1'b0);
            mode_d = MODE_IDLE;
          end
        end
        MODE_NAME: begin
          if (is_letter || is_numeral) begin
            if (len_q < 20'(KEY_CHARS)) begin
              pfx_d[len_q[2:0]] = b;
            end
            len_d = len_grow;
          end else begin
            a_emit = 1'b1;
            a_tok  = mk_tok(name_kind(pfx_q, len_q), org20, len_q, 1'b0);
            again  = 1'b1;
          end
        end
        MODE_OP: begin
          if (op_andor) begin
            if (b == pend_q) begin
              a_emit = 1'b1;
              a_tok  = mk_tok((pend_q == "&") ? K_AND : K_OR, org20, 20'd2, 1'b0);
              mode_d = MODE_IDLE;
            end else begin
              a_emit = 1'b1;
              a_tok  = mk_tok(K_END, org20, 20'd1, 1'b1);
              again  = 1'b1;
            end
          end else if (b == "=") begin
            a_emit = 1'b1;
            a_tok  = mk_tok(single_kind(pend_q) + 6'd1, org20, 20'd2, 1'b0);
            mode_d = MODE_IDLE;
          end else begin
            a_emit = 1'b1;
            a_tok  = mk_tok(single_kind(pend_q), org20, 20'd1, 1'b0);
            again  = 1'b1;
          end
        end
        default: begin
          again = 1'b1;
        end
      endcase

      // The byte opens a new token from the idle state.
      if (again) begin
        mode_d = MODE_IDLE;
        org_d  = pos_q;
        len_d  = 20'd1;
        if (is_ws) begin
          mode_d = MODE_IDLE;
        end else if (is_numeral) begin
          mode_d = MODE_INT;
        end else if (b == "\"") begin
          mode_d = MODE_STR;
        end else if (is_letter) begin
          pfx_d    = '0;
          pfx_d[0] = b;
          mode_d   = MODE_NAME;
        end else begin
          b_emit = 1'b1;
          case (b)
            "(": begin
              b_tok = mk_tok(K_LPAREN, pos20, 20'd1, 1'b0);
            end
            ")": begin
              b_tok = mk_tok(K_RPAREN, pos20, 20'd1, 1'b0);
            end
            "{": begin
              b_tok = mk_tok(K_LBRACE, pos20, 20'd1, 1'b0);
            end
            "}": begin
              b_tok = mk_tok(K_RBRACE, pos20, 20'd1, 1'b0);
            end
            "[": begin
              b_tok = mk_tok(K_LBRACK, pos20, 20'd1, 1'b0);
            end
            "]": begin
              b_tok = mk_tok(K_RBRACK, pos20, 20'd1, 1'b0);
            end
            ",": begin
              b_tok = mk_tok(K_COMMA, pos20, 20'd1, 1'b0);
            end
            8'h0A: begin
              b_tok = mk_tok(K_NL, pos20, 20'd1, 1'b0);
            end
            ";": begin
              b_tok = mk_tok(K_SEMI, pos20, 20'd1, 1'b0);
            end
            ".": begin
              b_tok = mk_tok(K_DOT, pos20, 20'd1, 1'b0);
            end
            ":": begin
              b_tok = mk_tok(K_COLON, pos20, 20'd1, 1'b0);
            end
            "+": begin
              b_tok = mk_tok(K_PLUS, pos20, 20'd1, 1'b0);
            end
            "-": begin
              b_tok = mk_tok(K_MINUS, pos20, 20'd1, 1'b0);
            end
            "*": begin
              b_tok = mk_tok(K_STAR, pos20, 20'd1, 1'b0);
            end
            "/": begin
              b_tok = mk_tok(K_SLASH, pos20, 20'd1, 1'b0);
            end
            "=", "!", ">", "<", "&", "|": begin
              b_emit = 1'b0;
              pend_d = b;
              mode_d = MODE_OP;
            end
            default: begin
              b_tok = mk_tok(K_END, pos20, 20'd1, 1'b1);
            end
          endcase
        end
      end

      if (mode_d != MODE_OP) begin
        pend_d = '0;
      end
      pos_d = (pos_q == POS_W'(TEXT_BYTES - 64'd1)) ? '0 : pos_q + POS_W'(1);
    end
  end

  // Pack the tokens in order and flag the last one of this word.
  always_comb begin
    push_o.cnt         = accept_i ? {a_emit & b_emit, a_emit ^ b_emit} : 2'd0;
    push_o.first       = a_emit ? a_tok : b_tok;
    push_o.first.last  = !(a_emit && b_emit);
    push_o.second      = b_tok;
    push_o.second.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      org_q  <= '0;
      pfx_q  <= '0;
      pend_q <= '0;
      len_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      org_q  <= org_d;
      pfx_q  <= pfx_d;
      pend_q <= pend_d;
      len_q  <= len_d;
    end
  end

  `STT_ASSERT_NEXT(a_eot_rewinds, accept_i && end_of_text_i, mode_q == MODE_IDLE && pos_q == '0)
  `STT_ASSERT(a_eot_emits, accept_i && end_of_text_i |-> push_o.cnt != 2'd0)
  `STT_ASSERT(a_pend_only_op, mode_q != MODE_OP |-> pend_q == '0)

endmodule

// ===== hw/rtl/stt_outq.sv =====
`include "source_text_tokenizer_core_assert.svh"

module stt_outq import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output tok_t  head_o,
  output logic  valid_o,
  output logic  full_o
);

  localparam int CNT_W = QPTR_W + 1;

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign wr_nx   = wr_q + QPTR_W'(1);
  assign wr_d    = wr_q + QPTR_W'(push_i.cnt);
  assign rd_d    = rd_q + QPTR_W'(pop_i);
  assign cnt_d   = cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop_i);
  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  // Room for two tokens is needed before the next word is taken.
  assign full_o  = (cnt_q > CNT_W'(QDEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `STT_ASSERT(a_no_overflow, cnt_q <= CNT_W'(QDEPTH))
  `STT_ASSERT(a_push_room, push_i.cnt != 2'd0 |-> cnt_q <= CNT_W'(QDEPTH - 2))
  `STT_ASSERT(a_pop_nonempty, pop_i |-> cnt_q != '0)

endmodule

// ===== hw/rtl/source_text_tokenizer_core.sv =====
// Streaming tokenizer for source text. Each input word carries one text byte,
// or an end-of-text mark that flushes the open token and emits the end token
// and rewinds the byte offset to zero for the next text. A byte that closes
// one token and opens another yields two tokens; the last token caused by a
// word carries run_last. The lexer state is updated in the cycle a word is
// accepted, and its tokens land in a four-entry output queue, so a new word
// is taken every cycle as long as the queue has room for two tokens. Words
// that give at most one token thus run at one per cycle; a word with two
// tokens needs the single output port (one token per cycle while unstalled)
// for both, so that port sets the sustained rate. With an empty queue, the
// first token of a word appears on the output in the cycle after acceptance.
// Token offsets count modulo TEXT_BYTES on 20 bits; lengths saturate.
module source_text_tokenizer_core import stt_pkg::*; #(
  parameter longint unsigned TEXT_BYTES = TEXT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [19:0] token_start_o,
  output logic [19:0] token_length_o,
  output logic        is_error_o,
  output logic        run_last_o
);

  logic  accept;
  logic  pop;
  logic  q_full;
  push_t push;
  tok_t  head;

  // The stall depends on registered queue occupancy only.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  stt_lex #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_lex (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .push_o       (push)
  );

  stt_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .valid_o(out_valid_o),
    .full_o (q_full)
  );

  // The head of the queue drives the result word directly.
  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.len;
  assign is_error_o     = head.err;
  assign run_last_o     = head.last;

endmodule

// ===== test/tb_source_text_tokenizer_core.sv =====
`timescale 1ns / 100ps

import stt_pkg::*;

localparam logic [7:0] CH_CR = 8'h0D;

typedef enum logic [2:0] {
  SCAN_IDLE,
  SCAN_INT,
  SCAN_FRAC,
  SCAN_STR,
  SCAN_NAME,
  SCAN_OP
} scan_mode_e;

// Tracks the lexer state, turns every accepted word into the tokens it must produce and
// compares the tokens that come out against them in order.
class tokenizer_scoreboard;
  string keywords [16] = '{"bool", "break", "continue", "else", "false", "float", "double",
                           "fn", "for", "if", "int", "let", "mut", "true", "type", "use"};

  scan_mode_e  mode;
  logic [19:0] next_offset;
  logic [19:0] tok_origin;
  logic [19:0] run_len;
  logic [7:0]  name_head [KEY_CHARS];
  logic [7:0]  held_op;
  tok_t        pending_tokens [$];
  tok_t        step_tokens [$];
  int          failures;

  function new();
    mode        = SCAN_IDLE;
    next_offset = '0;
    tok_origin  = '0;
    run_len     = '0;
    held_op     = '0;
    failures    = 0;
    foreach (name_head[i]) name_head[i] = '0;
  endfunction

  function int pending();
    return pending_tokens.size();
  endfunction

  function bit is_numeral(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function bit is_name_start(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function void grow_len();
    if (run_len < LEN_MAX) begin
      run_len++;
    end
  endfunction

  function void add_token(logic [5:0] kind, logic [19:0] start, logic [19:0] len, logic err);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.err   = err;
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function logic [5:0] keyword_kind();
    logic hit;
    for (int i = 0; i < 16; i++) begin
      if (run_len == 20'(keywords[i].len())) begin
        hit = 1'b1;
        for (int j = 0; j < keywords[i].len(); j++) begin
          if (name_head[j] != keywords[i][j]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          return 6'(K_KW0 + i);
        end
      end
    end
    return K_NAME;
  endfunction

  function logic [5:0] compare_kind(logic [7:0] op);
    case (op)
      "=": return K_ASSIGN;
      "!": return K_NOT;
      ">": return K_GT;
      default: return K_LT;
    endcase
  endfunction

  // Lexes a byte as the first byte of a new token.
  function void open_token(logic [7:0] b);
    tok_origin = next_offset;
    run_len    = 20'd1;
    if (b == " " || b == "\t" || b == CH_CR) begin
      return;
    end
    if (is_numeral(b)) begin
      mode = SCAN_INT;
      return;
    end
    if (b == "\"") begin
      mode = SCAN_STR;
      return;
    end
    if (is_name_start(b)) begin
      foreach (name_head[i]) name_head[i] = '0;
      name_head[0] = b;
      mode = SCAN_NAME;
      return;
    end
    case (b)
      "(": add_token(K_LPAREN, next_offset, 20'd1, 1'b0);
      ")": add_token(K_RPAREN, next_offset, 20'd1, 1'b0);
      "{": add_token(K_LBRACE, next_offset, 20'd1, 1'b0);
      "}": add_token(K_RBRACE, next_offset, 20'd1, 1'b0);
      "[": add_token(K_LBRACK, next_offset, 20'd1, 1'b0);
      "]": add_token(K_RBRACK, next_offset, 20'd1, 1'b0);
      ",": add_token(K_COMMA, next_offset, 20'd1, 1'b0);
      "\n": add_token(K_NL, next_offset, 20'd1, 1'b0);
      ";": add_token(K_SEMI, next_offset, 20'd1, 1'b0);
      ".": add_token(K_DOT, next_offset, 20'd1, 1'b0);
      ":": add_token(K_COLON, next_offset, 20'd1, 1'b0);
      "+": add_token(K_PLUS, next_offset, 20'd1, 1'b0);
      "-": add_token(K_MINUS, next_offset, 20'd1, 1'b0);
      "*": add_token(K_STAR, next_offset, 20'd1, 1'b0);
      "/": add_token(K_SLASH, next_offset, 20'd1, 1'b0);
      "=", "!", ">", "<", "&", "|": begin
        held_op = b;
        mode    = SCAN_OP;
      end
      default: add_token(K_END, next_offset, 20'd1, 1'b1);
    endcase
  endfunction

  function void predict_tokens(logic [7:0] b, logic eot);
    logic again;
    again = 1'b0;
    step_tokens.delete();
    if (eot) begin
      case (mode)
        SCAN_INT: add_token(K_INT, tok_origin, run_len, 1'b0);
        SCAN_FRAC: add_token(K_DBL, tok_origin, run_len, 1'b0);
        SCAN_STR: add_token(K_END, tok_origin, run_len, 1'b1);
        SCAN_NAME: add_token(keyword_kind(), tok_origin, run_len, 1'b0);
        SCAN_OP: begin
          if (held_op == "&" || held_op == "|") begin
            add_token(K_END, tok_origin, 20'd1, 1'b1);
          end else begin
            add_token(compare_kind(held_op), tok_origin, 20'd1, 1'b0);
          end
        end
        default: ;
      endcase
      add_token(K_END, next_offset, 20'd0, 1'b0);
      mode        = SCAN_IDLE;
      held_op     = '0;
      run_len     = '0;
      next_offset = '0;
    end else begin
      case (mode)
        SCAN_INT: begin
          if (is_numeral(b)) begin
            grow_len();
          end else if (b == ".") begin
            grow_len();
            mode = SCAN_FRAC;
          end else begin
            add_token(K_INT, tok_origin, run_len, 1'b0);
            again = 1'b1;
          end
        end
        SCAN_FRAC: begin
          if (is_numeral(b)) begin
            grow_len();
          end else if (b == ".") begin
            add_token(K_END, tok_origin, run_len, 1'b1);
            again = 1'b1;
          end else if (b == "f") begin
            add_token(K_FLT, tok_origin, run_len, 1'b0);
            mode = SCAN_IDLE;
          end else if (b == "d") begin
            add_token(K_DBL, tok_origin, run_len, 1'b0);
            mode = SCAN_IDLE;
          end else begin
            add_token(K_DBL, tok_origin, run_len, 1'b0);
            again = 1'b1;
          end
        end
        SCAN_STR: begin
          grow_len();
          if (b == "\"") begin
            add_token(K_STR, tok_origin, run_len, 1'b0);
            mode = SCAN_IDLE;
          end
        end
        SCAN_NAME: begin
          if (is_name_start(b) || is_numeral(b)) begin
            if (run_len < KEY_CHARS) begin
              name_head[run_len[2:0]] = b;
            end
            grow_len();
          end else begin
            add_token(keyword_kind(), tok_origin, run_len, 1'b0);
            again = 1'b1;
          end
        end
        SCAN_OP: begin
          if (held_op == "&" || held_op == "|") begin
            if (b == held_op) begin
              add_token(held_op == "&" ? K_AND : K_OR, tok_origin, 20'd2, 1'b0);
              mode = SCAN_IDLE;
            end else begin
              add_token(K_END, tok_origin, 20'd1, 1'b1);
              again = 1'b1;
            end
          end else if (b == "=") begin
            add_token(6'(compare_kind(held_op) + 6'd1), tok_origin, 20'd2, 1'b0);
            mode = SCAN_IDLE;
          end else begin
            add_token(compare_kind(held_op), tok_origin, 20'd1, 1'b0);
            again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase
      if (again) begin
        mode = SCAN_IDLE;
        open_token(b);
      end
      if (mode != SCAN_OP) begin
        held_op = '0;
      end
      next_offset = next_offset + 20'd1;
    end
    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
    end
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function void check_token(logic [5:0] kind, logic [19:0] start, logic [19:0] len,
                            logic err, logic last);
    tok_t want;
    if (pending_tokens.size() == 0) begin
      note_failure($sformatf("unexpected token: kind %0d start %0d len %0d err %b last %b",
                             kind, start, len, err, last));
      return;
    end
    want = pending_tokens.pop_front();
    if (kind !== want.kind || start !== want.start || len !== want.len ||
        err !== want.err || last !== want.last) begin
      note_failure($sformatf({"token mismatch: expected kind %0d start %0d len %0d err %b ",
                              "last %b, got kind %0d start %0d len %0d err %b last %b"},
                             want.kind, want.start, want.len, want.err, want.last,
                             kind, start, len, err, last));
    end
  endfunction
endclass

module tb_source_text_tokenizer_core;

  // Random words per idling phase, and the phase table itself: first no idling, then an
  // idle sender, then a stalling receiver, then both at once.
  localparam int WORDS_PER_PHASE = 440;
  localparam int PHASE_IDLE [4]  = '{0, 65, 0, 37};
  localparam int PHASE_STALL [4] = '{0, 0, 65, 37};

  // Length of the receiver hold-off that forces the output queue to fill up.
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;

  localparam string NAME_START = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string NAME_CHARS =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_byte_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [5:0]  token_kind_o;
  logic [19:0] token_start_o;
  logic [19:0] token_length_o;
  logic        is_error_o;
  logic        run_last_o;

  // Knobs shared between the stimulus and the receiver. Only the main process writes them.
  int send_idle_pct;
  int stall_pct;
  int hold_seq;
  int words_sent;

  tokenizer_scoreboard sb;

  source_text_tokenizer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .is_error_o     (is_error_o),
    .run_last_o     (run_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver side. The stall changes only at the falling edge. A new value of hold_seq
  // asks for a long hold-off, which this process counts down on its own; otherwise the
  // stall follows the stall rate of the current phase.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Every token taken at a rising edge is compared against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_token(token_kind_o, token_start_o, token_length_o, is_error_o, run_last_o);
    end
  end

  // Hard limit on the whole run, far above the slowest correct run.
  initial begin
    #(60_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] random_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Offers one word and returns at the rising edge where it is accepted. The payload is
  // set at a falling edge and is left alone while the block stalls.
  task automatic send_word(logic [7:0] b, logic eot);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.predict_tokens(b, eot);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b0);
    end
  endtask

  // The byte that rides along with an end-of-text word is ignored, so it is random.
  task automatic send_end();
    send_word(8'($urandom), 1'b1);
  endtask

  task automatic send_digits(int count);
    repeat (count) send_word(8'($urandom_range("0", "9")), 1'b0);
  endtask

  // Sends one token-shaped piece of text with random content. Most picks are well formed;
  // a few are lone operator bytes, unclosed strings, unknown bytes and plain noise, and
  // now and then the text ends, often in the middle of a token.
  task automatic send_random_token();
    int          choice;
    logic [7:0]  b;
    choice = $urandom_range(0, 19);
    case (choice)
      0, 1: begin
        case ($urandom_range(0, 2))
          0: send_word(" ", 1'b0);
          1: send_word("\t", 1'b0);
          default: send_word(CH_CR, 1'b0);
        endcase
      end
      2: send_word("\n", 1'b0);
      3, 4: send_word(random_from("(){}[],;.:+-*/"), 1'b0);
      5, 6: begin
        send_word(random_from("=!<>"), 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          send_word("=", 1'b0);
        end
      end
      7: begin
        // Usually a full && or ||; sometimes the second byte is missing.
        b = random_from("&|");
        send_word(b, 1'b0);
        if ($urandom_range(0, 3) != 0) begin
          send_word(b, 1'b0);
        end
      end
      8, 9: send_digits($urandom_range(1, 6));
      10, 11: begin
        send_digits($urandom_range(1, 4));
        send_word(".", 1'b0);
        send_digits($urandom_range(0, 4));
        case ($urandom_range(0, 5))
          0: send_word("f", 1'b0);
          1: send_word("d", 1'b0);
          2: send_word(".", 1'b0);
          default: ;
        endcase
      end
      12, 13: begin
        send_text(sb.keywords[$urandom_range(0, 15)]);
        if ($urandom_range(0, 3) == 0) begin
          send_word(random_from(NAME_CHARS), 1'b0);
        end
      end
      14, 15: begin
        send_word(random_from(NAME_START), 1'b0);
        repeat ($urandom_range(0, 12)) send_word(random_from(NAME_CHARS), 1'b0);
      end
      16: begin
        // Any byte may sit inside a string; a missing closing quote lets the string
        // swallow whatever follows.
        send_word("\"", 1'b0);
        repeat ($urandom_range(0, 10)) begin
          b = 8'($urandom_range(0, 255));
          send_word(b == "\"" ? 8'("q") : b, 1'b0);
        end
        if ($urandom_range(0, 7) != 0) begin
          send_word("\"", 1'b0);
        end
      end
      17: begin
        case ($urandom_range(0, 2))
          0: send_word(8'($urandom_range(128, 255)), 1'b0);
          1: send_word(8'($urandom_range(0, 8)), 1'b0);
          default: send_word(random_from("#$%@~'\\^?"), 1'b0);
        endcase
      end
      18: send_word(8'($urandom_range(0, 255)), 1'b0);
      default: send_end();
    endcase
  endtask

  initial begin
    int target;
    in_valid_i    = 1'b0;
    text_byte_i   = '0;
    end_of_text_i = 1'b0;
    rst_ni        = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_seq      = 0;
    words_sent    = 0;
    sb            = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed text. An f after an integer starts a name, a d suffix closes a decimal, a
    // second dot splits a number into an error and a dot, a lone & is an error before a
    // name, then an || and a <= followed by the two extreme byte values.
    send_text("7f 1.5d2.0.&x||<=");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_end();
    // A string left open at the end of the text, then operators pending at the end.
    send_text("\"ab");
    send_end();
    send_text(">");
    send_end();
    send_text("&");
    send_end();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = PHASE_IDLE[p];
      stall_pct     = PHASE_STALL[p];
      // In the first phase the receiver holds off for a long stretch while the sender
      // keeps offering words, so the output queue fills and the input stalls.
      if (p == 0) begin
        hold_seq++;
      end
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) begin
        send_random_token();
      end
    end
    send_end();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_lex.sv
hw/rtl/stt_outq.sv
hw/rtl/source_text_tokenizer_core.sv
test/tb_source_text_tokenizer_core.sv
